/* rtl/dds_pwm_pkg.sv */
// ----------------------------------------------------------------------------
// dds_pwm_pkg
// Shared types, codes and constants for the dds sine pwm tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pwm_pkg;

  localparam int PHASE_BITS     = 16;
  localparam int TABLE_IDX_BITS = 6;
  localparam int CMD_W          = 2;
  localparam int FREQ_W         = 16;
  localparam int DUR_W          = 16;
  localparam int SR_W           = 20;
  localparam int PERIOD_W       = 10;
  localparam int DUTY_W         = 10;
  localparam int PCT_W          = 7;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = SR_W;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 16;
  localparam int DIV_CNT_W      = $clog2(PHASE_BITS);

  // duty / 100 through a reciprocal that never overshoots, then one fix-up
  localparam int PROD_W      = PCT_W + PERIOD_W;
  localparam int RECIP       = 5242;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;
  localparam int PCT_SCALE   = 100;

  localparam logic [SR_W-1:0]       SR_RESET     = SR_W'(44100);
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = PERIOD_W'(1000);

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PWM_PERIOD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STACCATO = 2'd2;

  localparam logic [PCT_W-1:0] SINE_PCT [64] = '{
    7'd50, 7'd54, 7'd59, 7'd64, 7'd68, 7'd73, 7'd77, 7'd81,
    7'd85, 7'd88, 7'd91, 7'd93, 7'd95, 7'd97, 7'd98, 7'd99,
    7'd99, 7'd99, 7'd98, 7'd97, 7'd95, 7'd93, 7'd91, 7'd88,
    7'd85, 7'd81, 7'd77, 7'd73, 7'd68, 7'd64, 7'd59, 7'd54,
    7'd50, 7'd45, 7'd40, 7'd35, 7'd31, 7'd26, 7'd22, 7'd18,
    7'd14, 7'd11, 7'd8,  7'd6,  7'd4,  7'd2,  7'd1,  7'd0,
    7'd0,  7'd0,  7'd1,  7'd2,  7'd4,  7'd6,  7'd8,  7'd11,
    7'd14, 7'd18, 7'd22, 7'd26, 7'd31, 7'd35, 7'd40, 7'd45
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_START,
    ST_SMP_ADV,
    ST_SMP_MUL,
    ST_SMP_RECIP,
    ST_SMP_FIX,
    ST_MS,
    ST_STOP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic start_apply;
    logic smp_adv;
    logic smp_mul;
    logic smp_recip;
    logic smp_fix;
    logic ms_apply;
    logic stop_apply;
    logic capture;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/dds_sine_pwm_tone_generator.sv */
// ----------------------------------------------------------------------------
// dds_sine_pwm_tone_generator
// Sine tone source: phase accumulator, 64-entry sine table, pwm duty output.
// ----------------------------------------------------------------------------
// start: bit-serial increment divider, then the tone is applied; sample tick:
// phase advance, table entry times period, reciprocal divide by 100, fix-up;
// millisecond tick and stop: a direct update; each then waits for a free result slot
// one item in flight at a time; a new item is taken while a result waits
// synchronous reset: rate 44100, period 1000, staccato on, tone state cleared
`default_nettype none

module dds_sine_pwm_tone_generator
  import dds_pwm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // cmd, tone_freq, duration_ms
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // pwm_on, duty, tone_active
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ctrl_t             ctrl;
  logic              res_pwm_on;
  logic [DUTY_W-1:0] res_duty;
  logic              res_active;

  dds_pwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tdata[CMD_W-1:0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .ctrl      (ctrl)
  );

  dds_pwm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_freq    (s_tdata[CMD_W +: FREQ_W]),
    .in_dur     (s_tdata[CMD_W+FREQ_W +: DUR_W]),
    .res_pwm_on (res_pwm_on),
    .res_duty   (res_duty),
    .res_active (res_active)
  );

  assign m_tdata = {{(OUT_TDATA_W-DUTY_W-2){1'b0}}, res_active, res_duty, res_pwm_on};

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new item taken while one is in flight");

  a_capture_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |=> m_tvalid)
    else $error("captured result not presented");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !ctrl.capture |=> !m_tvalid)
    else $error("result repeated after transaction");

  a_capture_only_when_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |-> !m_tvalid || m_tready)
    else $error("result overwritten before transaction");

endmodule

`default_nettype wire

/* rtl/dds_pwm_ctrl.sv */
// ----------------------------------------------------------------------------
// dds_pwm_ctrl
// Sequencer: takes one item, steps the datapath through it, holds the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_pwm_ctrl
  import dds_pwm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ctrl_t                 ctrl
);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
      if (ctrl.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_START:  state_next = ST_DIV;
            CMD_SAMPLE: state_next = ST_SMP_ADV;
            CMD_MS:     state_next = ST_MS;
            default:    state_next = ST_STOP;
          endcase
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(PHASE_BITS - 1)) state_next = ST_START;
      end
      ST_START:     state_next = ST_FINISH;
      ST_SMP_ADV:   state_next = ST_SMP_MUL;
      ST_SMP_MUL:   state_next = ST_SMP_RECIP;
      ST_SMP_RECIP: state_next = ST_SMP_FIX;
      ST_SMP_FIX:   state_next = ST_FINISH;
      ST_MS:        state_next = ST_FINISH;
      ST_STOP:      state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl             = '0;
    in_ready         = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_DIV:       ctrl.div_step    = 1'b1;
      ST_START:     ctrl.start_apply = 1'b1;
      ST_SMP_ADV:   ctrl.smp_adv     = 1'b1;
      ST_SMP_MUL:   ctrl.smp_mul     = 1'b1;
      ST_SMP_RECIP: ctrl.smp_recip   = 1'b1;
      ST_SMP_FIX:   ctrl.smp_fix     = 1'b1;
      ST_MS:        ctrl.ms_apply    = 1'b1;
      ST_STOP:      ctrl.stop_apply  = 1'b1;
      ST_FINISH:    ctrl.capture     = out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dds_pwm_datapath.sv */
// ----------------------------------------------------------------------------
// dds_pwm_datapath
// Tone state, configuration registers, bit-serial increment divider,
// sine lookup with duty scaling, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_pwm_datapath
  import dds_pwm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_t                 ctrl,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [FREQ_W-1:0]     in_freq,
  input  wire logic [DUR_W-1:0]      in_dur,
  output logic                       res_pwm_on,
  output logic [DUTY_W-1:0]          res_duty,
  output logic                       res_active
);

  logic [SR_W-1:0]       sample_rate;
  logic [PERIOD_W-1:0]   pwm_period;
  logic                  staccato_mode;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [DUR_W-1:0]      ms_left;
  logic                  output_enabled;
  logic                  counting;
  logic [DUTY_W-1:0]     duty_now;

  logic [DUR_W-1:0]      dur_hold;
  logic [SR_W-1:0]       rem;
  logic [PHASE_BITS-1:0] quot;
  logic                  sat;

  logic [PROD_W-1:0]     prod;
  logic [QUOT_W-1:0]     q0;

  logic [SR_W:0]         rem_sh;
  logic                  rem_ge;
  logic [PROD_W+RECIP_W-1:0] recip_full;
  logic [PROD_W-1:0]     q0_x100;
  logic [PROD_W-1:0]     resid;
  logic [QUOT_W-1:0]     q_fixed;

  // one quotient bit per cycle; remainder stays below the divisor when the frequency starts below the rate
  assign rem_sh = {rem, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, sample_rate};

  assign recip_full = PROD_W'(prod) * RECIP_W'(RECIP);
  assign q0_x100    = PROD_W'(q0) * PROD_W'(PCT_SCALE);
  assign resid      = prod - q0_x100;
  assign q_fixed    = (resid >= PROD_W'(PCT_SCALE)) ? q0 + 1'b1 : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate    <= SR_RESET;
      pwm_period     <= PERIOD_RESET;
      staccato_mode  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SAMPLE_RATE: sample_rate   <= cfg_wdata;
        CFG_PWM_PERIOD:  pwm_period    <= cfg_wdata[PERIOD_W-1:0];
        CFG_STACCATO:    staccato_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc      <= '0;
      phase_step     <= '0;
      ms_left        <= '0;
      output_enabled <= 1'b0;
      counting       <= 1'b0;
      duty_now       <= '0;
    end else begin
      if (ctrl.start_apply) begin
        phase_acc      <= '0;
        phase_step     <= sat ? '1 : quot;
        ms_left        <= dur_hold;
        counting       <= dur_hold != '0;
        output_enabled <= !(dur_hold == '0 && staccato_mode);
      end
      if (ctrl.smp_adv) phase_acc <= phase_acc + phase_step;
      if (ctrl.smp_fix) duty_now <= q_fixed[DUTY_W-1:0];
      if (ctrl.ms_apply && counting) begin
        ms_left <= ms_left - 1'b1;
        if (ms_left == DUR_W'(1)) begin
          counting <= 1'b0;
          if (staccato_mode) output_enabled <= 1'b0;
        end
      end
      if (ctrl.stop_apply) output_enabled <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dur_hold <= in_dur;
      rem      <= SR_W'(in_freq);
      quot     <= '0;
      // quotient reaches 2^16 exactly when freq >= rate; a zero rate also saturates
      sat      <= (sample_rate == '0) || (SR_W'(in_freq) >= sample_rate);
    end else if (ctrl.div_step) begin
      rem  <= rem_ge ? SR_W'(rem_sh - {1'b0, sample_rate}) : rem_sh[SR_W-1:0];
      quot <= {quot[PHASE_BITS-2:0], rem_ge};
    end
    if (ctrl.smp_mul) begin
      prod <= PROD_W'(SINE_PCT[phase_acc[PHASE_BITS-1 -: TABLE_IDX_BITS]]) *
              PROD_W'(pwm_period);
    end
    if (ctrl.smp_recip) q0 <= recip_full[RECIP_SHIFT +: QUOT_W];
    if (ctrl.capture) begin
      res_pwm_on <= output_enabled;
      res_duty   <= duty_now;
      res_active <= counting;
    end
  end

endmodule

`default_nettype wire
